/* sv/gcb_pkg.sv */
`default_nettype none
package gcb_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int TURN_W       = 32;
  localparam int M_W          = 40;
  localparam int DIGIT_W      = 8;
  localparam int REM_W        = 6;
  localparam int XY_W         = 34;
  localparam int V_W          = 36;

  localparam int DIV_LAT  = M_W / DIGIT_W;
  localparam int SC_LAT   = CORDIC_STEPS + 2;
  localparam int MIX_LAT  = 2;
  localparam int AT_LAT   = CORDIC_STEPS + 2;
  localparam int PIPE_DEPTH = 1 + DIV_LAT + SC_LAT + MIX_LAT + AT_LAT + 1;

  // 45 * 2^33 keeps the dividend positive, plus 22 for round half up
  localparam logic [M_W-1:0] ROUND_BIAS = 40'd386547056662;
  localparam logic [14:0] RECIP45 = 15'd23302;
  localparam logic [13:0] DIV_BASE = 14'd45;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] UNIT_Q30    = 34'sd1073741824;
  localparam logic [TURN_W-1:0]      HALF_TURN   = 32'h8000_0000;
  localparam logic [5:0]             DEG_SCALE   = 6'd45;
  localparam logic [29:0]            PI_Q28_UP   = 30'd843314857;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [DIGIT_W-1:0] quo;
    logic [REM_W-1:0]   rem;
  } div_step_t;

  // one base-256 digit of a division by 45
  function automatic div_step_t div45_step(input logic [REM_W-1:0] rem,
                                           input logic [DIGIT_W-1:0] digit);
    logic [13:0] v;
    logic [28:0] p;
    div_step_t   r;
    v = {rem, digit};
    p = 29'(v) * 29'(RECIP45);
    r.quo = p[27:20];
    r.rem = REM_W'(v - 14'(r.quo) * DIV_BASE);
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/gcb_in_if.sv */
`default_nettype none
interface gcb_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] first_latitude;
  logic signed [31:0] first_longitude;
  logic signed [30:0] second_latitude;
  logic signed [31:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface
`default_nettype wire

/* sv/gcb_out_if.sv */
`default_nettype none
interface gcb_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] bearing_degrees;
  logic [18:0] bearing_radians;

  modport source (output valid, bearing_degrees, bearing_radians, input ready);
  modport sink (input valid, bearing_degrees, bearing_radians, output ready);
endinterface
`default_nettype wire

/* sv/great_circle_bearing.sv */
`default_nettype none
// Initial great-circle bearing from the first position to the second, plus a
// mounting offset, wrapped into [0, 360) and given in degrees and radians, both
// scaled by 65536. A fully pipelined datapath takes one transaction every clock
// unless the output stalls. Its stages are a front-end register, a divide-by-45
// angle conversion, a sine/cosine CORDIC, the multiply registers, an atan2
// CORDIC and the output scaling register. All but the offset path holds while
// the output is valid and not taken. An offset write takes effect after its
// registers and divide-by-45 conversion; there is no clearing pass after reset.
module great_circle_bearing (
  input  logic               clk_i,
  input  logic               rst_ni,
  gcb_in_if.sink             in_i,
  gcb_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic signed [25:0] cfg_wdata_i
);

  localparam int MW    = gcb_pkg::M_W;
  localparam int TW    = gcb_pkg::TURN_W;
  localparam int XyW   = gcb_pkg::XY_W;
  localparam int Depth = gcb_pkg::PIPE_DEPTH;

  logic [Depth-1:0]      vld_q;
  logic                  pipe_en;
  logic signed [25:0]    off_q;
  logic [MW-1:0]         off_m_q;
  logic [MW-1:0]         lat1_m_q, lat2_m_q, dlon_m_q;
  logic signed [32:0]    dlon;
  logic [TW-1:0]         lat1_t, lat2_t, dlon_t, off_t, bearing;
  logic signed [XyW-1:0] s1, c1, s2, c2, sd, cd, east, north;
  logic [37:0]           deg_p;
  logic [61:0]           rad_p;
  logic [24:0]           deg_q;
  logic [18:0]           rad_q;

  assign pipe_en    = ~(vld_q[Depth-1] & ~out_o.ready);
  assign in_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[Depth-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else if (cfg_we_i) begin
      off_q <= cfg_wdata_i;
    end
  end

  assign dlon = 33'(in_i.second_longitude) - 33'(in_i.first_longitude);

  always_ff @(posedge clk_i) begin
    off_m_q <= (MW'(off_q) <<< 13) + gcb_pkg::ROUND_BIAS;
    if (pipe_en) begin
      lat1_m_q <= (MW'(in_i.first_latitude) <<< 6) + gcb_pkg::ROUND_BIAS;
      lat2_m_q <= (MW'(in_i.second_latitude) <<< 6) + gcb_pkg::ROUND_BIAS;
      dlon_m_q <= (MW'(dlon) <<< 6) + gcb_pkg::ROUND_BIAS;
    end
  end

  gcb_div45 u_div_lat1 (.clk_i, .en_i(pipe_en), .m_i(lat1_m_q), .turn_o(lat1_t));
  gcb_div45 u_div_lat2 (.clk_i, .en_i(pipe_en), .m_i(lat2_m_q), .turn_o(lat2_t));
  gcb_div45 u_div_dlon (.clk_i, .en_i(pipe_en), .m_i(dlon_m_q), .turn_o(dlon_t));
  gcb_div45 u_div_off  (.clk_i, .en_i(1'b1),    .m_i(off_m_q),  .turn_o(off_t));

  gcb_sincos u_sc_lat1 (.clk_i, .en_i(pipe_en), .angle_i(lat1_t), .sin_o(s1), .cos_o(c1));
  gcb_sincos u_sc_lat2 (.clk_i, .en_i(pipe_en), .angle_i(lat2_t), .sin_o(s2), .cos_o(c2));
  gcb_sincos u_sc_dlon (.clk_i, .en_i(pipe_en), .angle_i(dlon_t), .sin_o(sd), .cos_o(cd));

  gcb_mix u_mix (
    .clk_i, .en_i(pipe_en),
    .s1_i(s1), .c1_i(c1), .s2_i(s2), .c2_i(c2), .sd_i(sd), .cd_i(cd),
    .east_o(east), .north_o(north)
  );

  gcb_atan u_atan (
    .clk_i, .en_i(pipe_en),
    .east_i(east), .north_i(north), .offset_i(off_t), .bearing_o(bearing)
  );

  assign deg_p = 38'(bearing) * 38'(gcb_pkg::DEG_SCALE);
  assign rad_p = 62'(bearing) * 62'(gcb_pkg::PI_Q28_UP);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      deg_q <= deg_p[37:13];
      rad_q <= rad_p[61:43];
    end
  end

  assign out_o.valid           = vld_q[Depth-1];
  assign out_o.bearing_degrees = deg_q;
  assign out_o.bearing_radians = rad_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.bearing_degrees < 25'd23592960)
    else $error("bearing degrees out of range");

  a_rad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.bearing_radians <= 19'd411774)
    else $error("bearing radians out of range");

endmodule
`default_nettype wire

/* sv/gcb_div45.sv */
`default_nettype none
module gcb_div45 (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gcb_pkg::M_W-1:0]     m_i,
  output logic [gcb_pkg::TURN_W-1:0]  turn_o
);

  localparam int MW     = gcb_pkg::M_W;
  localparam int DW     = gcb_pkg::DIGIT_W;
  localparam int TW     = gcb_pkg::TURN_W;
  localparam int Digits = gcb_pkg::DIV_LAT;

  logic [MW-1:0]               m_q   [Digits-1];
  logic [gcb_pkg::REM_W-1:0]   rem_q [Digits-1];
  logic [TW-1:0]               quo_q [Digits];

  for (genvar j = 0; j < Digits; j++) begin : g_dig
    logic [MW-1:0]             m_src;
    logic [gcb_pkg::REM_W-1:0] rem_src;
    logic [TW-1:0]             quo_src;
    gcb_pkg::div_step_t        st;

    if (j == 0) begin : g_first
      assign m_src   = m_i;
      assign rem_src = '0;
      assign quo_src = '0;
    end else begin : g_next
      assign m_src   = m_q[j-1];
      assign rem_src = rem_q[j-1];
      assign quo_src = quo_q[j-1];
    end

    assign st = gcb_pkg::div45_step(rem_src, m_src[MW-1-DW*j -: DW]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_src[TW-DW-1:0], st.quo};
      end
    end

    if (j < Digits - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[j]   <= m_src;
          rem_q[j] <= st.rem;
        end
      end
    end
  end

  assign turn_o = quo_q[Digits-1];

endmodule
`default_nettype wire

/* sv/gcb_sincos.sv */
`default_nettype none
module gcb_sincos (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [gcb_pkg::TURN_W-1:0]        angle_i,
  output logic signed [gcb_pkg::XY_W-1:0]   sin_o,
  output logic signed [gcb_pkg::XY_W-1:0]   cos_o
);

  localparam int XyW   = gcb_pkg::XY_W;
  localparam int Steps = gcb_pkg::CORDIC_STEPS;

  logic signed [XyW-1:0] x_q [1:Steps];
  logic signed [XyW-1:0] y_q [1:Steps];
  logic signed [XyW-1:0] z_q [0:Steps-1];
  logic                  flip_q [0:Steps];
  logic                  zero_q [0:Steps];
  logic                  flip;
  logic [gcb_pkg::TURN_W-1:0] rot;

  always_comb begin
    flip = (angle_i[31:30] == 2'b01) || (angle_i[31:30] == 2'b10);
    rot  = flip ? angle_i + gcb_pkg::HALF_TURN : angle_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= XyW'($signed(rot));
      flip_q[0] <= flip;
      zero_q[0] <= (angle_i == '0);
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_iter
    logic signed [XyW-1:0] xs, ys, xn, yn;

    if (i == 0) begin : g_seed
      assign xs = gcb_pkg::CORDIC_GAIN;
      assign ys = '0;
    end else begin : g_prev
      assign xs = x_q[i];
      assign ys = y_q[i];
    end

    always_comb begin
      if (z_q[i] >= 0) begin
        xn = xs - (ys >>> i);
        yn = ys + (xs >>> i);
      end else begin
        xn = xs + (ys >>> i);
        yn = ys - (xs >>> i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= xn;
        y_q[i+1]    <= yn;
        flip_q[i+1] <= flip_q[i];
        zero_q[i+1] <= zero_q[i];
      end
    end

    if (i < Steps - 1) begin : g_angle
      logic signed [XyW-1:0] step;
      assign step = $signed(XyW'(gcb_pkg::ATAN_TURNS[i]));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i+1] <= (z_q[i] >= 0) ? z_q[i] - step : z_q[i] + step;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[Steps]) begin
        sin_o <= '0;
        cos_o <= gcb_pkg::UNIT_Q30;
      end else if (flip_q[Steps]) begin
        sin_o <= -y_q[Steps];
        cos_o <= -x_q[Steps];
      end else begin
        sin_o <= y_q[Steps];
        cos_o <= x_q[Steps];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/gcb_mix.sv */
`default_nettype none
module gcb_mix (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [gcb_pkg::XY_W-1:0] s1_i,
  input  logic signed [gcb_pkg::XY_W-1:0] c1_i,
  input  logic signed [gcb_pkg::XY_W-1:0] s2_i,
  input  logic signed [gcb_pkg::XY_W-1:0] c2_i,
  input  logic signed [gcb_pkg::XY_W-1:0] sd_i,
  input  logic signed [gcb_pkg::XY_W-1:0] cd_i,
  output logic signed [gcb_pkg::XY_W-1:0] east_o,
  output logic signed [gcb_pkg::XY_W-1:0] north_o
);

  localparam int XyW = gcb_pkg::XY_W;

  logic signed [63:0]    pe, pt, pu, pv;
  logic signed [XyW-1:0] east_q, t_q, u_q, cd_q;

  assign pe = $signed(sd_i[31:0]) * $signed(c2_i[31:0]);
  assign pt = $signed(s1_i[31:0]) * $signed(c2_i[31:0]);
  assign pu = $signed(c1_i[31:0]) * $signed(s2_i[31:0]);
  assign pv = $signed(t_q[31:0]) * $signed(cd_q[31:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      east_q  <= pe[63:30];
      t_q     <= pt[63:30];
      u_q     <= pu[63:30];
      cd_q    <= cd_i;
      east_o  <= east_q;
      north_o <= u_q - $signed(pv[63:30]);
    end
  end

endmodule
`default_nettype wire

/* sv/gcb_atan.sv */
`default_nettype none
module gcb_atan (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [gcb_pkg::XY_W-1:0] east_i,
  input  logic signed [gcb_pkg::XY_W-1:0] north_i,
  input  logic [gcb_pkg::TURN_W-1:0]      offset_i,
  output logic [gcb_pkg::TURN_W-1:0]      bearing_o
);

  localparam int VW    = gcb_pkg::V_W;
  localparam int TW    = gcb_pkg::TURN_W;
  localparam int Steps = gcb_pkg::CORDIC_STEPS;

  logic signed [VW-1:0] x_q [0:Steps-1];
  logic signed [VW-1:0] y_q [0:Steps-1];
  logic [TW-1:0]        z_q [0:Steps];
  logic                 zero_q [0:Steps];
  logic signed [VW-1:0] xe, ye;

  assign xe = VW'(north_i);
  assign ye = VW'(east_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (east_i == '0) && (north_i == '0);
      if (north_i < 0) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= gcb_pkg::HALF_TURN;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_iter
    logic up;
    assign up = (y_q[i] > 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]    <= up ? z_q[i] + gcb_pkg::ATAN_TURNS[i]
                          : z_q[i] - gcb_pkg::ATAN_TURNS[i];
        zero_q[i+1] <= zero_q[i];
      end
    end

    if (i < Steps - 1) begin : g_vec
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[i+1] <= up ? x_q[i] + (y_q[i] >>> i) : x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= up ? y_q[i] - (x_q[i] >>> i) : y_q[i] + (x_q[i] >>> i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bearing_o <= (zero_q[Steps] ? '0 : z_q[Steps]) + offset_i;
    end
  end

endmodule
`default_nettype wire
